// ===== hdl/dtp_pkg.sv =====
`default_nettype none
package dtp_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int CFG_IDX_W   = 2;

  localparam logic [CFG_IDX_W-1:0] REG_UNSIGNED_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHORT_MODE    = 2'd1;

  localparam logic [7:0] CH_NUL   = 8'd0;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_PLUS  = 8'd43;
  localparam logic [7:0] CH_MINUS = 8'd45;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;

  typedef enum logic [2:0] {
    CL_NUL,
    CL_BLANK,
    CL_WHITE,
    CL_PLUS,
    CL_MINUS,
    CL_DIGIT,
    CL_OTHER
  } cls_t;

  typedef struct packed {
    cls_t       cls;
    logic [3:0] digit;
  } item_t;

  typedef enum logic [2:0] {
    PH_LEAD,
    PH_PRE,
    PH_SIGNED,
    PH_DIGITS,
    PH_TRAIL,
    PH_BAD
  } phase_t;

  typedef struct packed {
    logic unsigned_mode;
    logic short_mode;
  } cfg_t;

endpackage
`default_nettype wire

// ===== hdl/dtp_front.sv =====
`default_nettype none
module dtp_front (
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire logic [7:0]      ch,
  input  wire logic            q_full,
  output logic                 push,
  output dtp_pkg::item_t       item
);

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    item.digit = 4'd0;
    if (ch == dtp_pkg::CH_NUL) begin
      item.cls = dtp_pkg::CL_NUL;
    end else if (ch inside {dtp_pkg::CH_SPACE, dtp_pkg::CH_TAB}) begin
      item.cls = dtp_pkg::CL_BLANK;
    end else if (ch inside {[dtp_pkg::CH_LF:dtp_pkg::CH_CR]}) begin
      item.cls = dtp_pkg::CL_WHITE;
    end else if (ch == dtp_pkg::CH_PLUS) begin
      item.cls = dtp_pkg::CL_PLUS;
    end else if (ch == dtp_pkg::CH_MINUS) begin
      item.cls = dtp_pkg::CL_MINUS;
    end else if (ch inside {[dtp_pkg::CH_ZERO:dtp_pkg::CH_NINE]}) begin
      item.cls   = dtp_pkg::CL_DIGIT;
      // '0'..'9' carry their value in the low nibble
      item.digit = ch[3:0];
    end else begin
      item.cls = dtp_pkg::CL_OTHER;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/dtp_queue.sv =====
`default_nettype none
module dtp_queue #(
  parameter int DEPTH = dtp_pkg::QUEUE_DEPTH
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire dtp_pkg::item_t push_item,
  output logic                full,
  input  wire logic           pop,
  output logic                pop_valid,
  output dtp_pkg::item_t      pop_item
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  dtp_pkg::item_t   entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  assign full      = (count == CNT_W'(DEPTH));
  assign pop_valid = (count != '0);
  assign pop_item  = entries[rd_ptr];

  always_comb begin
    count_next = count;
    case ({push, pop})
      2'b10:   count_next = count + 1'b1;
      2'b01:   count_next = count - 1'b1;
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/dtp_back.sv =====
`default_nettype none
module dtp_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire dtp_pkg::cfg_t      cfg,
  input  wire logic               q_valid,
  input  wire dtp_pkg::item_t     q_item,
  output logic                    pop,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      value,
  output logic                    ok
);

  dtp_pkg::phase_t phase;
  dtp_pkg::phase_t phase_next;
  logic [31:0]     magnitude;
  logic [31:0]     magnitude_next;
  logic            negative;
  logic            negative_next;
  logic            saturated;
  logic            saturated_next;
  logic            first_zero;
  logic            first_zero_next;

  logic            room;
  logic            is_nul;
  logic [35:0]     prod;
  logic            prod_sat;
  logic [31:0]     lim;
  logic [31:0]     clamped;
  logic [31:0]     res;
  logic            fin_ok;
  dtp_pkg::phase_t eff_phase;

  assign room   = !out_valid || !out_stall;
  assign is_nul = (q_item.cls == dtp_pkg::CL_NUL);
  assign pop    = q_valid && (!is_nul || room);

  // magnitude * 10 + digit, saturating to all ones
  assign prod     = ({4'd0, magnitude} << 3) + ({4'd0, magnitude} << 1)
                    + {32'd0, q_item.digit};
  assign prod_sat = saturated || (prod[35:32] != 4'd0);

  // result at end of field
  always_comb begin
    lim     = negative ? 32'h8000_0000 : 32'h7FFF_FFFF;
    clamped = (saturated || magnitude > lim) ? lim : magnitude;
    fin_ok  = (phase == dtp_pkg::PH_DIGITS) || (phase == dtp_pkg::PH_TRAIL);
    if (cfg.unsigned_mode) begin
      res = saturated ? 32'hFFFF_FFFF : magnitude;
      if (negative) begin
        fin_ok = 1'b0;
      end
    end else begin
      res = negative ? (32'd0 - clamped) : clamped;
    end
    if (res == 32'd0 && !first_zero) begin
      fin_ok = 1'b0;
    end
    if (cfg.short_mode && !(res[31:15] == '0 || res[31:15] == '1)) begin
      fin_ok = 1'b0;
    end
  end

  always_comb begin
    phase_next      = phase;
    magnitude_next  = magnitude;
    negative_next   = negative;
    saturated_next  = saturated;
    first_zero_next = first_zero;
    eff_phase       = phase;
    if (pop) begin
      if (is_nul) begin
        phase_next      = dtp_pkg::PH_LEAD;
        magnitude_next  = 32'd0;
        negative_next   = 1'b0;
        saturated_next  = 1'b0;
        first_zero_next = 1'b0;
      end else begin
        // first non-blank character falls through into the prefix phase
        if (phase == dtp_pkg::PH_LEAD && q_item.cls != dtp_pkg::CL_BLANK) begin
          first_zero_next = (q_item.cls == dtp_pkg::CL_DIGIT) && (q_item.digit == 4'd0);
          eff_phase       = dtp_pkg::PH_PRE;
          phase_next      = dtp_pkg::PH_PRE;
        end
        case (eff_phase)
          dtp_pkg::PH_LEAD: begin
            phase_next = dtp_pkg::PH_LEAD;
          end
          dtp_pkg::PH_PRE: begin
            case (q_item.cls)
              dtp_pkg::CL_BLANK, dtp_pkg::CL_WHITE: phase_next = dtp_pkg::PH_PRE;
              dtp_pkg::CL_PLUS: phase_next = dtp_pkg::PH_SIGNED;
              dtp_pkg::CL_MINUS: begin
                if (cfg.unsigned_mode) begin
                  phase_next = dtp_pkg::PH_BAD;
                end else begin
                  negative_next = 1'b1;
                  phase_next    = dtp_pkg::PH_SIGNED;
                end
              end
              dtp_pkg::CL_DIGIT: begin
                saturated_next = prod_sat;
                magnitude_next = prod_sat ? 32'hFFFF_FFFF : prod[31:0];
                phase_next     = dtp_pkg::PH_DIGITS;
              end
              default: phase_next = dtp_pkg::PH_BAD;
            endcase
          end
          dtp_pkg::PH_SIGNED, dtp_pkg::PH_DIGITS: begin
            if (q_item.cls == dtp_pkg::CL_DIGIT) begin
              saturated_next = prod_sat;
              magnitude_next = prod_sat ? 32'hFFFF_FFFF : prod[31:0];
              phase_next     = dtp_pkg::PH_DIGITS;
            end else if (eff_phase == dtp_pkg::PH_DIGITS &&
                         q_item.cls == dtp_pkg::CL_BLANK) begin
              phase_next = dtp_pkg::PH_TRAIL;
            end else begin
              phase_next = dtp_pkg::PH_BAD;
            end
          end
          dtp_pkg::PH_TRAIL: begin
            if (q_item.cls != dtp_pkg::CL_BLANK) begin
              phase_next = dtp_pkg::PH_BAD;
            end
          end
          default: phase_next = dtp_pkg::PH_BAD;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= dtp_pkg::PH_LEAD;
      magnitude  <= 32'd0;
      negative   <= 1'b0;
      saturated  <= 1'b0;
      first_zero <= 1'b0;
    end else begin
      phase      <= phase_next;
      magnitude  <= magnitude_next;
      negative   <= negative_next;
      saturated  <= saturated_next;
      first_zero <= first_zero_next;
    end
  end

  // output register: a new result may load in the cycle the old one transfers
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && is_nul) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && is_nul) begin
      value <= fin_ok ? res : 32'd0;
      ok    <= fin_ok;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/decimal_integer_text_parser_unit.sv =====
// Decimal integer text parser.
// Input channel: one character per transfer on ch (in_valid / in_stall); a NUL
// character ends the field. Leading blanks, other whitespace, an optional sign,
// decimal digits and trailing blanks are accepted.
// Output channel: one transfer per field (out_valid / out_stall) carrying value
// and ok; value is 0 when ok is low. Characters other than NUL give no result.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 unsigned
// mode, 1 short mode); other indexes are ignored. Write only while idle.
// Throughput: one character per cycle while in_stall is low. A character lands
// in a small queue at its transfer and is consumed from there by the
// accumulator; a consumed NUL loads the result into the output register.
// When out_stall holds, the result waits in the output register; characters
// keep flowing until the queue (QUEUE_DEPTH entries) fills behind a pending NUL,
// then in_stall rises.
// Reset clears the queue, the field state, both mode registers and out_valid.
`default_nettype none
module decimal_integer_text_parser_unit #(
  parameter int QUEUE_DEPTH = dtp_pkg::QUEUE_DEPTH
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [7:0]                    ch,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic signed [31:0]                 value,
  output logic                               ok,
  input  wire logic                          cfg_we,
  input  wire logic [dtp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic                          cfg_data
);

  dtp_pkg::cfg_t  cfg;
  dtp_pkg::item_t front_item;
  dtp_pkg::item_t q_item;
  logic           push;
  logic           q_full;
  logic           q_valid;
  logic           pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        dtp_pkg::REG_UNSIGNED_MODE: cfg.unsigned_mode <= cfg_data;
        dtp_pkg::REG_SHORT_MODE:    cfg.short_mode    <= cfg_data;
        default: ;
      endcase
    end
  end

  dtp_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .ch       (ch),
    .q_full   (q_full),
    .push     (push),
    .item     (front_item)
  );

  dtp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (front_item),
    .full      (q_full),
    .pop       (pop),
    .pop_valid (q_valid),
    .pop_item  (q_item)
  );

  dtp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .value     (value),
    .ok        (ok)
  );

endmodule
`default_nettype wire

// ===== hdl/dtp_checker.sv =====
`default_nettype none
module dtp_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_stall,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic signed [31:0] value,
  input wire logic               ok
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(value) && $stable(ok))
    else $error("result changed while stalled");

  // a failed field always reports zero
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !ok |-> value == 32'sd0)
    else $error("failed field with nonzero value");

  // reset empties the output register
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  // reset empties the character queue
  a_reset_ready: assert property (@(posedge clk)
    rst |=> !in_stall)
    else $error("input stalled after reset");

endmodule

bind decimal_integer_text_parser_unit dtp_checker u_dtp_checker (.*);
`default_nettype wire

// ===== tb/decimal_integer_text_parser_unit_tb.sv =====
module decimal_integer_text_parser_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] CH_VT = 8'd11;
  localparam logic [dtp_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [dtp_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
  localparam int SETTLE_CYCLES = 8;
  localparam int SEG_CHARS = 240;
  localparam int HOLD_CYCLES = 80;

  typedef struct packed {
    logic [31:0] val;
    logic        ok;
  } field_result_t;

  class decimal_field_tracker;
    dtp_pkg::cfg_t   mode;
    dtp_pkg::phase_t ph;
    logic [31:0]     mag;
    logic            neg;
    logic            sat;
    logic            first_zero;
    field_result_t   parsed_fields_q[$];
    int              errors;
    int              n_chars;
    int              n_fields;
    int              n_ok;

    function new();
      mode = '0;
      errors = 0;
      n_chars = 0;
      n_fields = 0;
      n_ok = 0;
      clear_field();
    endfunction

    function void clear_field();
      ph = dtp_pkg::PH_LEAD;
      mag = '0;
      neg = 1'b0;
      sat = 1'b0;
      first_zero = 1'b0;
    endfunction

    function void set_reg(logic [dtp_pkg::CFG_IDX_W-1:0] idx, logic d);
      case (idx)
        dtp_pkg::REG_UNSIGNED_MODE: mode.unsigned_mode = d;
        dtp_pkg::REG_SHORT_MODE:    mode.short_mode = d;
        default: ;
      endcase
    endfunction

    function int pending();
      return parsed_fields_q.size();
    endfunction

    function bit is_blank(logic [7:0] c);
      return c == dtp_pkg::CH_SPACE || c == dtp_pkg::CH_TAB;
    endfunction

    function bit is_digit(logic [7:0] c);
      return c >= dtp_pkg::CH_ZERO && c <= dtp_pkg::CH_NINE;
    endfunction

    function void add_digit(logic [7:0] c);
      logic [63:0] t;
      t = 64'(mag) * 64'd10 + 64'(c - dtp_pkg::CH_ZERO);
      if (sat || t > 64'h0000_0000_FFFF_FFFF) begin
        sat = 1'b1;
        mag = '1;
      end else begin
        mag = t[31:0];
      end
    endfunction

    function void take_char(logic [7:0] c);
      field_result_t r;
      logic [31:0]   v;
      logic [31:0]   lim;
      logic [31:0]   m;
      logic          good;
      n_chars++;
      if (c == dtp_pkg::CH_NUL) begin
        good = (ph == dtp_pkg::PH_DIGITS) || (ph == dtp_pkg::PH_TRAIL);
        if (mode.unsigned_mode) begin
          if (neg) good = 1'b0;
          v = sat ? '1 : mag;
        end else begin
          lim = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
          m = (sat || mag > lim) ? lim : mag;
          v = neg ? (32'd0 - m) : m;
        end
        if (v == 32'd0 && !first_zero) good = 1'b0;
        // signed 16-bit range check on the wrapped pattern
        if (mode.short_mode && (v + 32'h0000_8000) >= 32'h0001_0000) good = 1'b0;
        r.val = good ? v : 32'd0;
        r.ok = good;
        parsed_fields_q.push_back(r);
        clear_field();
        return;
      end
      if (ph == dtp_pkg::PH_LEAD) begin
        if (is_blank(c)) return;
        first_zero = (c == dtp_pkg::CH_ZERO);
        ph = dtp_pkg::PH_PRE;
      end
      case (ph)
        dtp_pkg::PH_PRE: begin
          if (c == dtp_pkg::CH_SPACE || (c >= dtp_pkg::CH_TAB && c <= dtp_pkg::CH_CR)) begin
          end else if (c == dtp_pkg::CH_PLUS) begin
            ph = dtp_pkg::PH_SIGNED;
          end else if (c == dtp_pkg::CH_MINUS) begin
            if (mode.unsigned_mode) begin
              ph = dtp_pkg::PH_BAD;
            end else begin
              neg = 1'b1;
              ph = dtp_pkg::PH_SIGNED;
            end
          end else if (is_digit(c)) begin
            add_digit(c);
            ph = dtp_pkg::PH_DIGITS;
          end else begin
            ph = dtp_pkg::PH_BAD;
          end
        end
        dtp_pkg::PH_SIGNED: begin
          if (is_digit(c)) begin
            add_digit(c);
            ph = dtp_pkg::PH_DIGITS;
          end else begin
            ph = dtp_pkg::PH_BAD;
          end
        end
        dtp_pkg::PH_DIGITS: begin
          if (is_digit(c)) add_digit(c);
          else if (is_blank(c)) ph = dtp_pkg::PH_TRAIL;
          else ph = dtp_pkg::PH_BAD;
        end
        dtp_pkg::PH_TRAIL: begin
          if (!is_blank(c)) ph = dtp_pkg::PH_BAD;
        end
        default: ph = dtp_pkg::PH_BAD;
      endcase
    endfunction

    function void match_field(logic [31:0] v, logic k);
      field_result_t exp_r;
      if (parsed_fields_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result expected none actual value %h ok %b",
                 $time, v, k);
        return;
      end
      exp_r = parsed_fields_q.pop_front();
      n_fields++;
      if (k) n_ok++;
      if (v !== exp_r.val) begin
        errors++;
        $display("%0t: value mismatch expected %h actual %h", $time, exp_r.val, v);
      end
      if (k !== exp_r.ok) begin
        errors++;
        $display("%0t: ok mismatch expected %b actual %b", $time, exp_r.ok, k);
      end
    endfunction
  endclass

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic [7:0]                    ch = 8'd0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic signed [31:0]            value;
  logic                          ok;
  logic                          cfg_we = 1'b0;
  logic [dtp_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic                          cfg_data = 1'b0;

  decimal_field_tracker tracker;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_len = 0;

  decimal_integer_text_parser_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .ch        (ch),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .value     (value),
    .ok        (ok),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  initial begin
    #2ms;
    $display("decimal_integer_text_parser_unit_tb: errors");
    $finish;
  end

  // result side: random stall, or a long hold-off when requested
  initial begin
    logic stall_now;
    wait (!rst);
    forever begin
      if (hold_len > 0) begin
        stall_now = 1'b1;
        hold_len--;
      end else begin
        stall_now = ($urandom_range(99) < recv_idle_pct);
      end
      out_stall <= stall_now;
      @(posedge clk);
      if (out_valid && !stall_now) tracker.match_field(value, ok);
    end
  end

  task automatic send_ch(logic [7:0] c);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    ch <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.take_char(c);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_ch(s[i]);
  endtask

  // wait for every result, then let the character queue empty
  task automatic settle_block();
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [dtp_pkg::CFG_IDX_W-1:0] idx, logic d);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    tracker.set_reg(idx, d);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_field();
    logic [7:0] text[$];
    string      digits;
    longint     num;
    int         kind;
    longint     bounds[10] = '{64'd0, 64'd9, 64'd32767, 64'd32768, 64'd65535, 64'd65536,
                               64'd2147483647, 64'd2147483648, 64'd4294967295,
                               64'd4294967296};
    kind = $urandom_range(99);
    if (kind < 10) begin
      // noise: arbitrary non-NUL bytes
      repeat ($urandom_range(0, 6)) text.push_back(8'($urandom_range(1, 255)));
    end else begin
      repeat ($urandom_range(0, 2))
        text.push_back($urandom_range(1) ? dtp_pkg::CH_SPACE : dtp_pkg::CH_TAB);
      if ($urandom_range(9) == 0)
        text.push_back(8'($urandom_range(dtp_pkg::CH_TAB, dtp_pkg::CH_CR)));
      case ($urandom_range(9))
        0, 1, 2: text.push_back(dtp_pkg::CH_MINUS);
        3, 4:    text.push_back(dtp_pkg::CH_PLUS);
        default: ;
      endcase
      case ($urandom_range(19))
        0: ;
        10, 11, 12, 13, 14, 15: begin
          num = bounds[$urandom_range(9)];
          case ($urandom_range(2))
            0: if (num > 0) num--;
            2: num++;
            default: ;
          endcase
          digits = $sformatf("%0d", num);
          for (int i = 0; i < digits.len(); i++) text.push_back(digits[i]);
        end
        16, 17: begin
          repeat ($urandom_range(10, 13))
            text.push_back(8'(dtp_pkg::CH_ZERO + $urandom_range(9)));
        end
        default: begin
          if ($urandom_range(4) == 0)
            repeat ($urandom_range(1, 3)) text.push_back(dtp_pkg::CH_ZERO);
          num = $urandom_range(10 ** $urandom_range(1, 6) - 1, 0);
          digits = $sformatf("%0d", num);
          for (int i = 0; i < digits.len(); i++) text.push_back(digits[i]);
        end
      endcase
      repeat ($urandom_range(0, 2))
        text.push_back($urandom_range(1) ? dtp_pkg::CH_SPACE : dtp_pkg::CH_TAB);
      if (kind < 22)
        text.insert($urandom_range(text.size(), 0), 8'($urandom_range(1, 255)));
    end
    foreach (text[i]) send_ch(text[i]);
    send_ch(dtp_pkg::CH_NUL);
  endtask

  initial begin
    int start_chars;
    bit held;
    tracker = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed fields, signed mode
    send_idle_pct = 13;
    recv_idle_pct = 45;
    write_reg(REG_SPARE_A, 1'b1);
    write_reg(REG_SPARE_B, 1'b1);
    send_ch(dtp_pkg::CH_NUL);
    send_text(" \t0");
    send_ch(dtp_pkg::CH_NUL);
    send_text("\t-0 ");
    send_ch(dtp_pkg::CH_NUL);
    send_ch(CH_VT);
    send_text("+9");
    send_ch(dtp_pkg::CH_NUL);
    send_text("7x");
    send_ch(dtp_pkg::CH_NUL);
    send_ch(8'hFF);
    send_ch(dtp_pkg::CH_NUL);
    // minus taken in signed mode, field closed in unsigned mode
    send_text("-5");
    settle_block();
    write_reg(dtp_pkg::REG_UNSIGNED_MODE, 1'b1);
    send_ch(dtp_pkg::CH_NUL);
    settle_block();
    // saturated all ones reads as -1 and fits short mode
    write_reg(dtp_pkg::REG_SHORT_MODE, 1'b1);
    send_text("4294967296");
    send_ch(dtp_pkg::CH_NUL);

    for (int seg = 0; seg < 6; seg++) begin
      settle_block();
      write_reg(dtp_pkg::REG_UNSIGNED_MODE, seg[0]);
      write_reg(dtp_pkg::REG_SHORT_MODE, seg[1]);
      if (seg < 2) begin
        send_idle_pct = 13;
        recv_idle_pct = 45;
      end else if (seg < 4) begin
        send_idle_pct = 45;
        recv_idle_pct = 13;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      start_chars = tracker.n_chars;
      held = 1'b0;
      while (tracker.n_chars - start_chars < SEG_CHARS) begin
        send_field();
        // hold results back while characters keep coming
        if (!held && (seg == 1 || seg == 4) && tracker.n_chars - start_chars > 100) begin
          hold_len = HOLD_CYCLES;
          held = 1'b1;
        end
      end
    end

    settle_block();
    $display("%0d characters sent, %0d fields parsed, %0d of them valid integers",
             tracker.n_chars, tracker.n_fields, tracker.n_ok);
    $display("all unsigned/short mode pairs, swapped idling, output hold-offs");
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("decimal_integer_text_parser_unit_tb: clean");
    end else begin
      $display("decimal_integer_text_parser_unit_tb: errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/dtp_pkg.sv
hdl/dtp_front.sv
hdl/dtp_queue.sv
hdl/dtp_back.sv
hdl/decimal_integer_text_parser_unit.sv
hdl/dtp_checker.sv
tb/decimal_integer_text_parser_unit_tb.sv
